### design/html_pkg.sv
// ----------------------------------------------------------------------------
// html_pkg
// Shared types, codes and constants of the header table match lookup unit.
// ----------------------------------------------------------------------------
package html_pkg;

   localparam int MAX_ROWS_DEF       = 512;
   localparam int MAX_MATCH_KEYS_DEF = 4;
   localparam int MAX_SET_KEYS_DEF   = 4;

   localparam int NUM_KEYS  = 4;
   localparam int ROW_OUT_W = 9;
   localparam int Q_SHIFT   = 16;

   localparam logic [1:0] ACT_CLEAR  = 2'd0;
   localparam logic [1:0] ACT_APPEND = 2'd1;
   localparam logic [1:0] ACT_LOOKUP = 2'd2;

   localparam logic [2:0] CSR_NUM_MATCH_KEYS = 3'd0;
   localparam logic [2:0] CSR_NUM_SET_KEYS   = 3'd1;
   localparam logic [2:0] CSR_SYNC_MODE      = 3'd2;
   localparam logic [2:0] CSR_SCALE_0        = 3'd3;
   localparam logic [2:0] CSR_SCALE_1        = 3'd4;
   localparam logic [2:0] CSR_SCALE_2        = 3'd5;
   localparam logic [2:0] CSR_SCALE_3        = 3'd6;

   localparam logic signed [31:0] SCALE_ONE = 32'sd65536;

   typedef struct packed {
      logic [1:0]         action;
      logic signed [31:0] key_0;
      logic signed [31:0] key_1;
      logic signed [31:0] key_2;
      logic signed [31:0] key_3;
      logic signed [31:0] row_value_0;
      logic signed [31:0] row_value_1;
      logic signed [31:0] row_value_2;
      logic signed [31:0] row_value_3;
   } req_word_type;

   typedef struct packed {
      logic                 matched;
      logic                 table_full;
      logic [ROW_OUT_W-1:0] matched_row;
      logic signed [31:0]   result_0;
      logic signed [31:0]   result_1;
      logic signed [31:0]   result_2;
      logic signed [31:0]   result_3;
   } rsp_word_type;

   typedef logic [NUM_KEYS-1:0][31:0] word_array_type;

   // handed from cell to cell along the compare chain
   typedef struct packed {
      logic valid;
      logic last;
      logic match;
   } link_type;

   typedef struct packed {
      logic flush;
      logic wr_en;
   } cell_ctl_type;

endpackage

### design/html_cell.sv
// ----------------------------------------------------------------------------
// html_cell
// One compare cell: holds one match key column, compares it against the
// trace key for the row passing by and hands the result to the next cell.
// ----------------------------------------------------------------------------
module html_cell #(
   parameter int MAX_ROWS = html_pkg::MAX_ROWS_DEF,
   parameter int ROW_W    = $clog2(MAX_ROWS)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  html_pkg::cell_ctl_type ctl,
   input  logic [ROW_W-1:0]     wr_row,
   input  logic signed [31:0]   key,
   input  logic                 cmp_en,
   input  html_pkg::link_type   link_in,
   input  logic [ROW_W-1:0]     row_in,
   output html_pkg::link_type   link_out,
   output logic [ROW_W-1:0]     row_out
);

   logic signed [31:0] mem [MAX_ROWS];
   logic signed [31:0] rd_ff;
   logic               valid_ff;
   logic               last_ff;
   logic               match_ff;
   logic [ROW_W-1:0]   row_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_row] <= key;
      end
      rd_ff <= mem[row_in];
   end

   always_ff @(posedge clock) begin
      if (reset || ctl.flush) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= link_in.valid;
      end
      last_ff  <= link_in.last;
      match_ff <= link_in.match;
      row_ff   <= row_in;
   end

   always_comb begin
      link_out.valid = valid_ff;
      link_out.last  = last_ff;
      link_out.match = match_ff & (~cmp_en | (rd_ff == key));
      row_out        = row_ff;
   end

endmodule

### design/html_scale.sv
// ----------------------------------------------------------------------------
// html_scale
// Set value store and Q16.16 scaler: reads the hit row, then multiplies one
// value per step, truncates toward zero and saturates to 32-bit signed.
// ----------------------------------------------------------------------------
module html_scale #(
   parameter int MAX_ROWS     = html_pkg::MAX_ROWS_DEF,
   parameter int MAX_SET_KEYS = html_pkg::MAX_SET_KEYS_DEF,
   parameter int ROW_W        = $clog2(MAX_ROWS)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     wr_en,
   input  logic [ROW_W-1:0]         wr_row,
   input  html_pkg::word_array_type wr_values,
   input  logic                     start,
   input  logic [ROW_W-1:0]         rd_row,
   input  logic [2:0]               num_set,
   input  html_pkg::word_array_type scale,
   output logic                     done,
   output html_pkg::word_array_type result
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_READ,
      S_MUL,
      S_ADJ
   } state_type;

   logic signed [31:0] mem [MAX_SET_KEYS][MAX_ROWS];
   logic signed [31:0] rd_ff [MAX_SET_KEYS];

   state_type                state_ff;
   logic [1:0]               col_ff;
   logic signed [63:0]       product_ff;
   logic                     done_ff;
   html_pkg::word_array_type result_ff;

   logic signed [31:0] sel_val;
   logic signed [63:0] rounded;
   logic signed [63:0] quot;
   logic signed [31:0] sat_val;

   always_ff @(posedge clock) begin
      for (int j = 0; j < MAX_SET_KEYS; j++) begin
         if (wr_en) begin
            mem[j][wr_row] <= $signed(wr_values[j]);
         end
         if (start) begin
            rd_ff[j] <= mem[j][rd_row];
         end
      end
   end

   always_comb begin
      sel_val = '0;
      for (int j = 0; j < MAX_SET_KEYS; j++) begin
         if (col_ff == 2'(j) && {1'b0, col_ff} < num_set) begin
            sel_val = rd_ff[j];
         end
      end
   end

   always_comb begin
      rounded = product_ff + (product_ff[63] ? 64'sd65535 : 64'sd0);
      quot    = rounded >>> html_pkg::Q_SHIFT;
      if (quot > 64'sd2147483647) begin
         sat_val = 32'sh7fffffff;
      end else if (quot < -64'sd2147483648) begin
         sat_val = 32'sh80000000;
      end else begin
         sat_val = quot[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         col_ff   <= '0;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= (state_ff == S_ADJ) && (col_ff == 2'(html_pkg::NUM_KEYS - 1));
         case (state_ff)
            S_IDLE: begin
               col_ff <= '0;
               if (start) begin
                  state_ff <= S_READ;
               end
            end
            S_READ: begin
               state_ff <= S_MUL;
            end
            S_MUL: begin
               product_ff <= sel_val * $signed(scale[col_ff]);
               state_ff   <= S_ADJ;
            end
            S_ADJ: begin
               result_ff[col_ff] <= sat_val;
               col_ff            <= col_ff + 2'd1;
               if (col_ff == 2'(html_pkg::NUM_KEYS - 1)) begin
                  state_ff <= S_IDLE;
               end else begin
                  state_ff <= S_MUL;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign done   = done_ff;
   assign result = result_ff;

endmodule

### design/header_table_match_lookup_unit.sv
// ----------------------------------------------------------------------------
// header_table_match_lookup_unit
// Keyed table lookup: clear, append rows, and search for the first row whose
// match keys equal a trace's keys, returning Q16.16-scaled set values.
// ----------------------------------------------------------------------------
// One word is handled at a time. The result of a clear or append passes from
// EXEC through DONE into the result register. A lookup streams stored rows
// through the chain of compare cells at one row per cycle from the search
// start; on a miss its result passes from the end of the chain through DONE
// into the result register. A hit runs the scaler, which reads the hit row and
// runs one shared 32x32 multiplier over the four values; a miss skips the
// scaler. A new word is accepted while the previous result still waits on the
// result port.
module header_table_match_lookup_unit #(
   parameter int MAX_ROWS       = html_pkg::MAX_ROWS_DEF,
   parameter int MAX_MATCH_KEYS = html_pkg::MAX_MATCH_KEYS_DEF,
   parameter int MAX_SET_KEYS   = html_pkg::MAX_SET_KEYS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  html_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output html_pkg::rsp_word_type rsp_word,
   input  logic                  csr_write,
   input  logic [2:0]            csr_index,
   input  logic [31:0]           csr_data
);

   localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CNT_W = $clog2(MAX_ROWS + 1);

   typedef enum logic [2:0] {
      IDLE,
      EXEC,
      SEARCH,
      SCALE,
      DONE
   } state_type;

   // configuration
   logic [2:0]               num_match_ff;
   logic [2:0]               num_set_ff;
   logic                     sync_ff;
   html_pkg::word_array_type scale_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_match_ff <= 3'd1;
         num_set_ff   <= 3'd1;
         sync_ff      <= 1'b0;
         for (int i = 0; i < html_pkg::NUM_KEYS; i++) begin
            scale_ff[i] <= html_pkg::SCALE_ONE;
         end
      end else if (csr_write) begin
         case (csr_index)
            html_pkg::CSR_NUM_MATCH_KEYS: num_match_ff <= csr_data[2:0];
            html_pkg::CSR_NUM_SET_KEYS:   num_set_ff   <= csr_data[2:0];
            html_pkg::CSR_SYNC_MODE:      sync_ff      <= csr_data[0];
            html_pkg::CSR_SCALE_0:        scale_ff[0]  <= csr_data;
            html_pkg::CSR_SCALE_1:        scale_ff[1]  <= csr_data;
            html_pkg::CSR_SCALE_2:        scale_ff[2]  <= csr_data;
            html_pkg::CSR_SCALE_3:        scale_ff[3]  <= csr_data;
            default: begin
            end
         endcase
      end
   end

   logic [2:0] nm_eff;
   logic [2:0] ns_eff;

   always_comb begin
      if (num_match_ff == 3'd0) begin
         nm_eff = 3'd1;
      end else if (num_match_ff > 3'(MAX_MATCH_KEYS)) begin
         nm_eff = 3'(MAX_MATCH_KEYS);
      end else begin
         nm_eff = num_match_ff;
      end
      if (num_set_ff == 3'd0) begin
         ns_eff = 3'd1;
      end else if (num_set_ff > 3'(MAX_SET_KEYS)) begin
         ns_eff = 3'(MAX_SET_KEYS);
      end else begin
         ns_eff = num_set_ff;
      end
   end

   // control
   state_type              state_ff;
   html_pkg::req_word_type req_ff;
   logic [CNT_W-1:0]       row_count_ff;
   logic [ROW_W-1:0]       start_ff;
   logic [ROW_W-1:0]       issue_ff;
   logic                   issuing_ff;
   logic                   hit_ff;
   logic                   full_ff;
   logic [ROW_W-1:0]       hit_row_ff;
   logic                   rsp_valid_ff;
   html_pkg::rsp_word_type rsp_word_ff;

   html_pkg::word_array_type key_vec;
   html_pkg::word_array_type value_vec;
   html_pkg::word_array_type scaled;
   html_pkg::cell_ctl_type   cell_ctl;
   html_pkg::link_type       link [MAX_MATCH_KEYS+1];
   logic [ROW_W-1:0]         link_row [MAX_MATCH_KEYS+1];
   logic                     req_accept;
   logic                     append_go;
   logic                     scale_start;
   logic                     scale_done;
   logic                     chain_hit;
   logic                     chain_miss;
   logic                     last_row;
   logic                     rsp_load;

   always_comb begin
      key_vec[0]   = req_ff.key_0;
      key_vec[1]   = req_ff.key_1;
      key_vec[2]   = req_ff.key_2;
      key_vec[3]   = req_ff.key_3;
      value_vec[0] = req_ff.row_value_0;
      value_vec[1] = req_ff.row_value_1;
      value_vec[2] = req_ff.row_value_2;
      value_vec[3] = req_ff.row_value_3;
   end

   assign req_stall  = (state_ff != IDLE);
   assign req_accept = req_valid && !req_stall;
   assign append_go  = (state_ff == EXEC) && (req_ff.action == html_pkg::ACT_APPEND)
                       && (row_count_ff != CNT_W'(MAX_ROWS));
   assign last_row   = ((CNT_W'(issue_ff) + CNT_W'(1)) == row_count_ff);
   assign rsp_load   = (state_ff == DONE) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      cell_ctl.flush = (state_ff != SEARCH);
      cell_ctl.wr_en = append_go;
      link[0].valid  = (state_ff == SEARCH) && issuing_ff;
      link[0].last   = last_row;
      link[0].match  = 1'b1;
      link_row[0]    = issue_ff;
   end

   genvar k;
   generate
      for (k = 0; k < MAX_MATCH_KEYS; k++) begin : g_cell
         html_cell #(
            .MAX_ROWS (MAX_ROWS),
            .ROW_W    (ROW_W)
         ) u_cell (
            .clock    (clock),
            .reset    (reset),
            .ctl      (cell_ctl),
            .wr_row   (row_count_ff[ROW_W-1:0]),
            .key      ($signed(key_vec[k])),
            .cmp_en   (3'(k) < nm_eff),
            .link_in  (link[k]),
            .row_in   (link_row[k]),
            .link_out (link[k+1]),
            .row_out  (link_row[k+1])
         );
      end
   endgenerate

   assign chain_hit   = (state_ff == SEARCH) && link[MAX_MATCH_KEYS].valid
                        && link[MAX_MATCH_KEYS].match;
   assign chain_miss  = (state_ff == SEARCH) && link[MAX_MATCH_KEYS].valid
                        && !link[MAX_MATCH_KEYS].match && link[MAX_MATCH_KEYS].last;
   assign scale_start = chain_hit;

   html_scale #(
      .MAX_ROWS     (MAX_ROWS),
      .MAX_SET_KEYS (MAX_SET_KEYS),
      .ROW_W        (ROW_W)
   ) u_scale (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (append_go),
      .wr_row    (row_count_ff[ROW_W-1:0]),
      .wr_values (value_vec),
      .start     (scale_start),
      .rd_row    (link_row[MAX_MATCH_KEYS]),
      .num_set   (ns_eff),
      .scale     (scale_ff),
      .done      (scale_done),
      .result    (scaled)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         row_count_ff <= '0;
         start_ff     <= '0;
         issuing_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            IDLE: begin
               if (req_accept) begin
                  req_ff   <= req_word;
                  state_ff <= EXEC;
               end
            end
            EXEC: begin
               hit_ff     <= 1'b0;
               full_ff    <= (req_ff.action == html_pkg::ACT_APPEND) && !append_go;
               hit_row_ff <= '0;
               case (req_ff.action)
                  html_pkg::ACT_CLEAR: begin
                     row_count_ff <= '0;
                     start_ff     <= '0;
                     state_ff     <= DONE;
                  end
                  html_pkg::ACT_APPEND: begin
                     if (append_go) begin
                        row_count_ff <= row_count_ff + CNT_W'(1);
                     end
                     state_ff <= DONE;
                  end
                  html_pkg::ACT_LOOKUP: begin
                     if (CNT_W'(start_ff) >= row_count_ff) begin
                        start_ff <= '0;
                        state_ff <= DONE;
                     end else begin
                        issue_ff   <= start_ff;
                        issuing_ff <= 1'b1;
                        state_ff   <= SEARCH;
                     end
                  end
                  default: begin
                     state_ff <= DONE;
                  end
               endcase
            end
            SEARCH: begin
               if (chain_hit) begin
                  hit_ff     <= 1'b1;
                  hit_row_ff <= link_row[MAX_MATCH_KEYS];
                  start_ff   <= sync_ff ? link_row[MAX_MATCH_KEYS] : '0;
                  issuing_ff <= 1'b0;
                  state_ff   <= SCALE;
               end else if (chain_miss) begin
                  start_ff   <= '0;
                  issuing_ff <= 1'b0;
                  state_ff   <= DONE;
               end else if (issuing_ff) begin
                  issue_ff <= issue_ff + ROW_W'(1);
                  if (last_row) begin
                     issuing_ff <= 1'b0;
                  end
               end
            end
            SCALE: begin
               if (scale_done) begin
                  state_ff <= DONE;
               end
            end
            DONE: begin
               if (rsp_load) begin
                  rsp_word_ff.matched     <= hit_ff;
                  rsp_word_ff.table_full  <= full_ff;
                  rsp_word_ff.matched_row <= html_pkg::ROW_OUT_W'(hit_row_ff);
                  rsp_word_ff.result_0    <= hit_ff ? scaled[0] : '0;
                  rsp_word_ff.result_1    <= hit_ff ? scaled[1] : '0;
                  rsp_word_ff.result_2    <= hit_ff ? scaled[2] : '0;
                  rsp_word_ff.result_3    <= hit_ff ? scaled[3] : '0;
                  state_ff                <= IDLE;
               end
            end
            default: begin
               state_ff <= IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   a_row_count_bound: assert property (@(posedge clock) disable iff (reset)
      row_count_ff <= CNT_W'(MAX_ROWS))
      else $error("row count past table size");

   a_hit_to_scale: assert property (@(posedge clock) disable iff (reset)
      chain_hit |=> state_ff == SCALE)
      else $error("chain hit did not start scaling");

   a_done_in_scale: assert property (@(posedge clock) disable iff (reset)
      scale_done |-> state_ff == SCALE)
      else $error("scaler finished outside scale phase");

   a_issue_in_table: assert property (@(posedge clock) disable iff (reset)
      link[0].valid |-> CNT_W'(issue_ff) < row_count_ff)
      else $error("row issued beyond row count");

   a_hit_not_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_word_ff.matched && rsp_word_ff.table_full))
      else $error("word flags both hit and full");

endmodule

### tb/tb_header_table_match_lookup_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_header_table_match_lookup_unit
// Self-checking bench for the keyed table lookup unit. Words are sent through
// a valid/stall channel and every accepted request is run through a local
// model of the row table, which queues the word expected back. Each returned
// word is compared field by field in arrival order. Directed cases cover
// defaults, key and scale extremes, key count clamping, resumed search, a
// full table and a long hold-off on the result side; random phases then
// rebuild small tables under random settings with random gaps on both sides.
// ----------------------------------------------------------------------------
module tb_header_table_match_lookup_unit;

   localparam logic [1:0] ACT_UNUSED      = 2'd3;
   localparam logic [2:0] CSR_UNKNOWN     = 3'd7;
   localparam logic [31:0] S32_MAX        = 32'h7fff_ffff;
   localparam logic [31:0] S32_MIN        = 32'h8000_0000;
   localparam longint      S64_OF_MAX     = 64'sd2147483647;
   localparam longint      S64_OF_MIN     = -64'sd2147483648;
   localparam int          RANDOM_WORDS   = 120;
   localparam int          RSP_HOLD_CYCLES = 300;
   localparam int          WATCHDOG_LIMIT = 5000;
   localparam int          SETTLE_CYCLES  = 600;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   html_pkg::req_word_type req_word;
   logic                   rsp_valid;
   logic                   rsp_stall;
   html_pkg::rsp_word_type rsp_word;
   logic                   csr_write;
   logic [2:0]             csr_index;
   logic [31:0]            csr_data;

   header_table_match_lookup_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // table model state
   logic signed [31:0] row_keys_m [html_pkg::MAX_ROWS_DEF][html_pkg::NUM_KEYS];
   logic signed [31:0] row_vals_m [html_pkg::MAX_ROWS_DEF][html_pkg::NUM_KEYS];
   int unsigned        rows_held;
   int unsigned        scan_from;
   logic [2:0]         cfg_match_cnt;
   logic [2:0]         cfg_set_cnt;
   logic               cfg_sync;
   logic signed [31:0] cfg_scale [html_pkg::NUM_KEYS];

   html_pkg::rsp_word_type pending_table_rsp [$];
   int           error_count;
   int           words_sent;
   int           quiet_cycles;
   bit           req_idle_on;
   bit           rsp_idle_on;
   int unsigned  hold_requests;
   int unsigned  hold_seen;
   int unsigned  rsp_wait_left;
   int unsigned  rsp_hold_left;
   logic [31:0]  key_pool [html_pkg::NUM_KEYS][2];

   function automatic int clamp_count(input logic [2:0] n, input int top);
      if (n == 3'd0)
         return 1;
      if (int'(n) > top)
         return top;
      return int'(n);
   endfunction

   function automatic logic signed [31:0] scale_q16(input logic signed [31:0] v,
                                                     input logic signed [31:0] s);
      longint prod;
      longint quo;
      prod = longint'(v) * longint'(s);
      quo  = prod / 64'sd65536;
      if (quo > S64_OF_MAX)
         return S32_MAX;
      if (quo < S64_OF_MIN)
         return S32_MIN;
      return quo[31:0];
   endfunction

   function automatic html_pkg::rsp_word_type table_response(
      input html_pkg::req_word_type w);
      html_pkg::rsp_word_type r;
      logic signed [31:0] keys [html_pkg::NUM_KEYS];
      logic signed [31:0] res [html_pkg::NUM_KEYS];
      int                 nm;
      int                 ns;
      int                 i;
      int                 k;
      int                 row;
      bit                 hit;
      bit                 same;
      r = '0;
      keys[0] = w.key_0;
      keys[1] = w.key_1;
      keys[2] = w.key_2;
      keys[3] = w.key_3;
      for (k = 0; k < html_pkg::NUM_KEYS; k++)
         res[k] = '0;
      case (w.action)
         html_pkg::ACT_CLEAR: begin
            rows_held = 0;
            scan_from = 0;
         end
         html_pkg::ACT_APPEND: begin
            if (rows_held >= html_pkg::MAX_ROWS_DEF) begin
               r.table_full = 1'b1;
            end else begin
               for (k = 0; k < html_pkg::NUM_KEYS; k++)
                  row_keys_m[rows_held][k] = keys[k];
               row_vals_m[rows_held][0] = w.row_value_0;
               row_vals_m[rows_held][1] = w.row_value_1;
               row_vals_m[rows_held][2] = w.row_value_2;
               row_vals_m[rows_held][3] = w.row_value_3;
               rows_held++;
            end
         end
         html_pkg::ACT_LOOKUP: begin
            nm  = clamp_count(cfg_match_cnt, html_pkg::MAX_MATCH_KEYS_DEF);
            ns  = clamp_count(cfg_set_cnt, html_pkg::MAX_SET_KEYS_DEF);
            hit = 1'b0;
            row = 0;
            for (i = scan_from; i < rows_held && !hit; i++) begin
               same = 1'b1;
               for (k = 0; k < nm; k++)
                  if (row_keys_m[i][k] != keys[k])
                     same = 1'b0;
               if (same) begin
                  hit = 1'b1;
                  row = i;
               end
            end
            if (hit) begin
               r.matched     = 1'b1;
               r.matched_row = html_pkg::ROW_OUT_W'(row);
               for (k = 0; k < ns; k++)
                  res[k] = scale_q16(row_vals_m[row][k], cfg_scale[k]);
               scan_from = cfg_sync ? row : 0;
            end else begin
               scan_from = 0;
            end
            r.result_0 = res[0];
            r.result_1 = res[1];
            r.result_2 = res[2];
            r.result_3 = res[3];
         end
         default: ;
      endcase
      return r;
   endfunction

   // model update on register writes and accepted words
   always @(posedge clock) begin
      if (reset) begin
         rows_held     = 0;
         scan_from     = 0;
         cfg_match_cnt = 3'd1;
         cfg_set_cnt   = 3'd1;
         cfg_sync      = 1'b0;
         for (int k = 0; k < html_pkg::NUM_KEYS; k++)
            cfg_scale[k] = html_pkg::SCALE_ONE;
      end else begin
         if (csr_write) begin
            case (csr_index)
               html_pkg::CSR_NUM_MATCH_KEYS: cfg_match_cnt = csr_data[2:0];
               html_pkg::CSR_NUM_SET_KEYS:   cfg_set_cnt   = csr_data[2:0];
               html_pkg::CSR_SYNC_MODE:      cfg_sync      = csr_data[0];
               html_pkg::CSR_SCALE_0:        cfg_scale[0]  = csr_data;
               html_pkg::CSR_SCALE_1:        cfg_scale[1]  = csr_data;
               html_pkg::CSR_SCALE_2:        cfg_scale[2]  = csr_data;
               html_pkg::CSR_SCALE_3:        cfg_scale[3]  = csr_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            pending_table_rsp.push_back(table_response(req_word));
      end
   end

   task automatic check_table_rsp(input html_pkg::rsp_word_type exp,
                                  input html_pkg::rsp_word_type got);
      if (got.matched !== exp.matched) begin
         $error("matched: expected %0d, got %0d", exp.matched, got.matched);
         error_count++;
      end
      if (got.table_full !== exp.table_full) begin
         $error("table_full: expected %0d, got %0d", exp.table_full, got.table_full);
         error_count++;
      end
      if (got.matched_row !== exp.matched_row) begin
         $error("matched_row: expected %0d, got %0d", exp.matched_row, got.matched_row);
         error_count++;
      end
      if (got.result_0 !== exp.result_0) begin
         $error("result_0: expected %0d, got %0d", exp.result_0, got.result_0);
         error_count++;
      end
      if (got.result_1 !== exp.result_1) begin
         $error("result_1: expected %0d, got %0d", exp.result_1, got.result_1);
         error_count++;
      end
      if (got.result_2 !== exp.result_2) begin
         $error("result_2: expected %0d, got %0d", exp.result_2, got.result_2);
         error_count++;
      end
      if (got.result_3 !== exp.result_3) begin
         $error("result_3: expected %0d, got %0d", exp.result_3, got.result_3);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_table_rsp.size() == 0) begin
            $error("result word arrived with none pending");
            error_count++;
         end else begin
            check_table_rsp(pending_table_rsp.pop_front(), rsp_word);
         end
      end
   end

   // result side: random wait per word, plus a long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall     <= 1'b0;
         rsp_wait_left = 0;
         rsp_hold_left = 0;
         hold_seen     = hold_requests;
      end else begin
         if (hold_requests != hold_seen) begin
            hold_seen     = hold_requests;
            rsp_hold_left = RSP_HOLD_CYCLES;
         end else if (rsp_hold_left != 0) begin
            rsp_hold_left--;
         end
         if (rsp_valid && !rsp_stall)
            rsp_wait_left = rsp_idle_on ? $urandom_range(0, 13) : 0;
         else if (rsp_valid && rsp_wait_left != 0)
            rsp_wait_left--;
         rsp_stall <= (rsp_hold_left != 0) || (rsp_wait_left != 0);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic html_pkg::req_word_type make_word(input logic [1:0] act,
      input logic [31:0] k0, k1, k2, k3, v0, v1, v2, v3);
      html_pkg::req_word_type w;
      w.action      = act;
      w.key_0       = k0;
      w.key_1       = k1;
      w.key_2       = k2;
      w.key_3       = k3;
      w.row_value_0 = v0;
      w.row_value_1 = v1;
      w.row_value_2 = v2;
      w.row_value_3 = v3;
      return w;
   endfunction

   task automatic send_word(input html_pkg::req_word_type w);
      int gap;
      gap = req_idle_on ? $urandom_range(0, 13) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (req_stall);
      if (w.action != ACT_UNUSED)
         words_sent++;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_table_rsp.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic put_csr(input logic [2:0] idx, input logic [31:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
   endtask

   task automatic configure(input logic [2:0] match_cnt, input logic [2:0] set_cnt,
                            input logic sync, input logic [31:0] s0, s1, s2, s3);
      logic [31:0] junk;
      junk = $urandom;
      put_csr(html_pkg::CSR_NUM_MATCH_KEYS, {junk[31:3], match_cnt});
      put_csr(html_pkg::CSR_NUM_SET_KEYS, {junk[31:3], set_cnt});
      put_csr(html_pkg::CSR_SYNC_MODE, {junk[31:1], sync});
      put_csr(html_pkg::CSR_SCALE_0, s0);
      put_csr(html_pkg::CSR_SCALE_1, s1);
      put_csr(html_pkg::CSR_SCALE_2, s2);
      put_csr(html_pkg::CSR_SCALE_3, s3);
      put_csr(CSR_UNKNOWN, junk);
      csr_write <= 1'b0;
   endtask

   function automatic logic [31:0] random_scale();
      case ($urandom_range(0, 6))
         0: return html_pkg::SCALE_ONE;
         1: return S32_MAX;
         2: return S32_MIN;
         3: return -html_pkg::SCALE_ONE;
         4: return $urandom_range(0, 262143) - 131072;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [31:0] random_value();
      case ($urandom_range(0, 7))
         0: return S32_MAX;
         1: return S32_MIN;
         2: return $urandom_range(0, 255) - 128;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [31:0] pool_key(input int col);
      case ($urandom_range(0, 9))
         0: return $urandom;
         1: return $urandom_range(0, 1) ? S32_MAX : S32_MIN;
         default: return key_pool[col][$urandom_range(0, 1)];
      endcase
   endfunction

   function automatic html_pkg::req_word_type random_row();
      return make_word(html_pkg::ACT_APPEND,
                       pool_key(0), pool_key(1), pool_key(2), pool_key(3),
                       random_value(), random_value(), random_value(), random_value());
   endfunction

   task automatic test_defaults_after_reset();
      send_word(make_word(html_pkg::ACT_LOOKUP, 0, 0, 0, 0, 0, 0, 0, 0));
      send_word(make_word(ACT_UNUSED, S32_MAX, S32_MIN, S32_MAX, S32_MIN, -1, -1, -1, -1));
      send_word(make_word(html_pkg::ACT_APPEND, S32_MIN, S32_MAX, 0, -1,
                          S32_MAX, S32_MIN, 1, -1));
      send_word(make_word(html_pkg::ACT_APPEND, S32_MAX, S32_MIN, -1, 0,
                          S32_MIN, S32_MAX, -5, 12345));
      send_word(make_word(html_pkg::ACT_APPEND, S32_MIN, 0, 0, -1, -1, 2, 3, 4));
      send_word(make_word(html_pkg::ACT_LOOKUP, S32_MIN, 0, 0, 0, 0, 0, 0, 0));
      send_word(make_word(html_pkg::ACT_LOOKUP, S32_MAX, 0, 0, 0, 0, 0, 0, 0));
      send_word(make_word(html_pkg::ACT_LOOKUP, 7, 0, 0, 0, 0, 0, 0, 0));
   endtask

   task automatic test_key_and_scale_extremes();
      drain_results();
      configure(3'd4, 3'd4, 1'b0, S32_MAX, S32_MIN, 32'd3, -html_pkg::SCALE_ONE);
      send_word(make_word(html_pkg::ACT_LOOKUP, S32_MIN, S32_MAX, 0, -1, 0, 0, 0, 0));
      send_word(make_word(html_pkg::ACT_LOOKUP, S32_MAX, S32_MIN, -1, 0, 0, 0, 0, 0));
      send_word(make_word(html_pkg::ACT_LOOKUP, S32_MIN, 0, 0, -1, 0, 0, 0, 0));
      send_word(make_word(html_pkg::ACT_LOOKUP, S32_MIN, 0, 0, 0, 0, 0, 0, 0));
   endtask

   task automatic test_key_count_clamping();
      drain_results();
      configure(3'd0, 3'd0, 1'b0, html_pkg::SCALE_ONE, html_pkg::SCALE_ONE,
                html_pkg::SCALE_ONE, html_pkg::SCALE_ONE);
      send_word(make_word(html_pkg::ACT_LOOKUP, S32_MIN, 1, 2, 3, 0, 0, 0, 0));
      drain_results();
      configure(3'd7, 3'd7, 1'b0, html_pkg::SCALE_ONE, 32'h0002_0000, 32'h0000_8000,
                html_pkg::SCALE_ONE);
      send_word(make_word(html_pkg::ACT_LOOKUP, S32_MIN, 0, 0, -1, 0, 0, 0, 0));
      drain_results();
      configure(3'd5, 3'd6, 1'b0, html_pkg::SCALE_ONE, html_pkg::SCALE_ONE, 32'd1,
                html_pkg::SCALE_ONE);
      send_word(make_word(html_pkg::ACT_LOOKUP, S32_MAX, S32_MIN, -1, 0, 0, 0, 0, 0));
   endtask

   task automatic test_resumed_search();
      drain_results();
      configure(3'd1, 3'd2, 1'b1, html_pkg::SCALE_ONE, -html_pkg::SCALE_ONE,
                html_pkg::SCALE_ONE, html_pkg::SCALE_ONE);
      send_word(make_word(html_pkg::ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0));
      send_word(make_word(html_pkg::ACT_APPEND, 100, 0, 0, 0, 10, 11, 0, 0));
      send_word(make_word(html_pkg::ACT_APPEND, -100, 0, 0, 0, 20, 21, 0, 0));
      send_word(make_word(html_pkg::ACT_APPEND, 100, 0, 0, 0, 30, 31, 0, 0));
      send_word(make_word(html_pkg::ACT_APPEND, -100, 0, 0, 0, 40, 41, 0, 0));
      // hit row stays the start, no wrap past the end
      send_word(make_word(html_pkg::ACT_LOOKUP, 100, 0, 0, 0, 0, 0, 0, 0));
      send_word(make_word(html_pkg::ACT_LOOKUP, 100, 0, 0, 0, 0, 0, 0, 0));
      send_word(make_word(html_pkg::ACT_LOOKUP, -100, 0, 0, 0, 0, 0, 0, 0));
      send_word(make_word(html_pkg::ACT_LOOKUP, 100, 0, 0, 0, 0, 0, 0, 0));
      send_word(make_word(html_pkg::ACT_LOOKUP, -100, 0, 0, 0, 0, 0, 0, 0));
      send_word(make_word(html_pkg::ACT_LOOKUP, 100, 0, 0, 0, 0, 0, 0, 0));
      send_word(make_word(html_pkg::ACT_LOOKUP, 100, 0, 0, 0, 0, 0, 0, 0));
      send_word(make_word(html_pkg::ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0));
      send_word(make_word(html_pkg::ACT_LOOKUP, 100, 0, 0, 0, 0, 0, 0, 0));
   endtask

   task automatic test_table_full();
      int r;
      drain_results();
      req_idle_on = 1'b1;
      rsp_idle_on <= 1'b1;
      configure(3'd2, 3'd4, 1'b1, html_pkg::SCALE_ONE, -html_pkg::SCALE_ONE,
                32'h0002_0000, 32'hffff_8000);
      send_word(make_word(html_pkg::ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0));
      for (r = 0; r < html_pkg::MAX_ROWS_DEF; r++)
         send_word(make_word(html_pkg::ACT_APPEND, r, $urandom_range(0, 1), $urandom,
                             $urandom, random_value(), random_value(), random_value(),
                             random_value()));
      send_word(make_word(html_pkg::ACT_APPEND, 1, 0, 0, 0, 1, 1, 1, 1));
      send_word(make_word(html_pkg::ACT_APPEND, S32_MAX, 1, 0, 0, 1, 1, 1, 1));
      send_word(make_word(html_pkg::ACT_LOOKUP, html_pkg::MAX_ROWS_DEF - 1, 0, 0, 0,
                          0, 0, 0, 0));
      send_word(make_word(html_pkg::ACT_LOOKUP, html_pkg::MAX_ROWS_DEF - 1, 1, 0, 0,
                          0, 0, 0, 0));
      send_word(make_word(html_pkg::ACT_LOOKUP, 5, 0, 0, 0, 0, 0, 0, 0));
      send_word(make_word(html_pkg::ACT_LOOKUP, 5, 1, 0, 0, 0, 0, 0, 0));
      repeat (8)
         send_word(make_word(html_pkg::ACT_LOOKUP,
                             $urandom_range(0, html_pkg::MAX_ROWS_DEF - 1),
                             $urandom_range(0, 1), $urandom, $urandom, 0, 0, 0, 0));
   endtask

   task automatic test_result_hold_off();
      int i;
      drain_results();
      req_idle_on = 1'b0;
      rsp_idle_on <= 1'b0;
      configure(3'd1, 3'd4, 1'b0, html_pkg::SCALE_ONE, 32'h0001_8000,
                -html_pkg::SCALE_ONE, 32'd65535);
      send_word(make_word(html_pkg::ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0));
      for (i = 0; i < 4; i++)
         send_word(make_word(html_pkg::ACT_APPEND, i, 0, 0, 0,
                             random_value(), random_value(), random_value(), random_value()));
      // sender waits for every result before the hold-off starts
      drain_results();
      hold_requests <= hold_requests + 1;
      for (i = 0; i < 16; i++)
         send_word(make_word(html_pkg::ACT_LOOKUP, i % 6, $urandom, 0, 0, 0, 0, 0, 0));
      drain_results();
   endtask

   task automatic test_random_tables();
      html_pkg::req_word_type w;
      html_pkg::req_word_type rows [$];
      int           target;
      int           n_rows;
      int           c;
      int           j;
      target = words_sent + RANDOM_WORDS;
      while (words_sent < target) begin
         drain_results();
         req_idle_on = ($urandom_range(0, 3) != 0);
         rsp_idle_on <= ($urandom_range(0, 3) != 0);
         configure(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                   1'($urandom_range(0, 1)),
                   random_scale(), random_scale(), random_scale(), random_scale());
         for (c = 0; c < html_pkg::NUM_KEYS; c++)
            for (j = 0; j < 2; j++)
               key_pool[c][j] = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 3);
         send_word(make_word(html_pkg::ACT_CLEAR, $urandom, $urandom, $urandom, $urandom,
                             $urandom, $urandom, $urandom, $urandom));
         rows.delete();
         n_rows = $urandom_range(1, 24);
         repeat (n_rows) begin
            w = random_row();
            rows.push_back(w);
            send_word(w);
         end
         repeat (2 * n_rows + 4) begin
            case ($urandom_range(0, 19))
               0: begin
                  send_word(make_word(ACT_UNUSED, $urandom, $urandom, $urandom, $urandom,
                                      $urandom, $urandom, $urandom, $urandom));
               end
               1: begin
                  send_word(make_word(html_pkg::ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0));
                  rows.delete();
               end
               2, 3: begin
                  w = random_row();
                  rows.push_back(w);
                  send_word(w);
               end
               default: begin
                  if (rows.size() == 0 || $urandom_range(0, 6) == 0) begin
                     w = random_row();
                  end else begin
                     w = rows[$urandom_range(0, rows.size() - 1)];
                     if ($urandom_range(0, 4) == 0) begin
                        case ($urandom_range(0, 3))
                           0: w.key_0 = pool_key(0);
                           1: w.key_1 = pool_key(1);
                           2: w.key_2 = pool_key(2);
                           default: w.key_3 = pool_key(3);
                        endcase
                     end
                  end
                  w.action      = html_pkg::ACT_LOOKUP;
                  w.row_value_0 = $urandom;
                  w.row_value_1 = $urandom;
                  w.row_value_2 = $urandom;
                  w.row_value_3 = $urandom;
                  send_word(w);
               end
            endcase
         end
      end
   endtask

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_word      = '0;
      rsp_stall     = 1'b0;
      csr_write     = 1'b0;
      csr_index     = '0;
      csr_data      = '0;
      error_count   = 0;
      words_sent    = 0;
      quiet_cycles  = 0;
      req_idle_on   = 1'b1;
      rsp_idle_on   = 1'b1;
      hold_requests = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_defaults_after_reset();
      test_key_and_scale_extremes();
      test_key_count_clamping();
      test_resumed_search();
      test_result_hold_off();
      test_table_full();
      test_random_tables();
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_table_rsp.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
